// ===== design/ramb_pkg.sv =====
package ramb_pkg;

    localparam int NUM_SLOTS   = 8;
    localparam int PARAM_WIDTH = 32;

    localparam int CMD_W     = 2;
    localparam int TID_W     = 3;
    localparam int SIG_W     = 8;
    localparam int FIELD_W   = 32;
    localparam int OWNER_W   = 4;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam logic [SIG_W-1:0] SIG_NULL = '0;

    typedef enum logic [CMD_W-1:0] {
        CMD_UPDATE     = 2'd0,
        CMD_RESET      = 2'd1,
        CMD_SEND       = 2'd2,
        CMD_SEND_PARAM = 2'd3
    } cmd_t;

    typedef logic [PARAM_WIDTH-1:0] slot_param_t;

    // The stored parameter is the field value cut or widened to the slot width.
    function automatic slot_param_t to_slot(input logic [FIELD_W-1:0] p);
        logic [63:0] w;
        w = 64'(p);
        return w[PARAM_WIDTH-1:0];
    endfunction

    function automatic logic [FIELD_W-1:0] to_field(input slot_param_t s);
        logic [63:0] w;
        w = 64'(s);
        return w[FIELD_W-1:0];
    endfunction

endpackage

// ===== design/ramb_in_if.sv =====
interface ramb_in_if;
    import ramb_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [TID_W-1:0]   thread_id;
    logic [SIG_W-1:0]   signal;
    logic [FIELD_W-1:0] param;

    modport source (output valid, command, thread_id, signal, param, input ready);
    modport sink   (input valid, command, thread_id, signal, param, output ready);
endinterface

// ===== design/ramb_out_if.sv =====
interface ramb_out_if;
    import ramb_pkg::*;

    logic               valid;
    logic               ready;
    logic               delivered;
    logic [TID_W-1:0]   deliver_thread;
    logic [SIG_W-1:0]   deliver_signal;
    logic [FIELD_W-1:0] deliver_param;
    logic               send_accepted;

    modport source (output valid, delivered, deliver_thread, deliver_signal, deliver_param,
                    send_accepted, input ready);
    modport sink   (input valid, delivered, deliver_thread, deliver_signal, deliver_param,
                    send_accepted, output ready);
endinterface

// ===== design/request_ack_mailbox_core.sv =====
// Request/acknowledge mailbox with one slot per thread. Every item produces exactly one
// result item; work waits while the output register holds a result. A send or a reset works
// on its thread's slot; an update walks the slots from slot 0 upward through a single slot
// compare unit, one slot per cycle, and stops at the first new request, or at once if its
// thread may not run updates. The input is taken again when the working phase ends, while
// the result may still wait in the output register. The owner register is written through
// cfg_we and cfg_wdata and resets to the slot count, which lets any thread run updates.
module request_ack_mailbox_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ramb_pkg::OWNER_W-1:0]  cfg_wdata,
    ramb_in_if.sink                       in_ch,
    ramb_out_if.source                    out_ch
);
    import ramb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WORK = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg;
    logic [TID_W-1:0]    tid_reg;
    logic [SIG_W-1:0]    sig_reg;
    logic [FIELD_W-1:0]  param_reg;
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    logic                range_ok_reg;
    logic [OWNER_W-1:0]  owner_reg;

    logic [SIG_W-1:0]    req_reg [NUM_SLOTS];
    logic [SIG_W-1:0]    ack_reg [NUM_SLOTS];
    slot_param_t         slot_param_reg [NUM_SLOTS];

    logic                out_valid_reg;
    logic                delivered_reg;
    logic [TID_W-1:0]    deliver_thread_reg;
    logic [SIG_W-1:0]    deliver_signal_reg;
    logic [FIELD_W-1:0]  deliver_param_reg;
    logic                send_accepted_reg;

    logic                in_fire, go, finish, permitted, last_slot;
    logic [SIG_W-1:0]    cur_req, cur_ack;
    slot_param_t         cur_par;
    logic                req_we, ack_we, par_we;
    logic [SIG_W-1:0]    req_wdata, ack_wdata;
    logic                res_delivered, res_accepted;
    logic [SIG_W-1:0]    res_signal;
    logic [FIELD_W-1:0]  res_param;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign go          = (state_reg == ST_WORK) && !out_valid_reg;

    assign cur_req   = req_reg[idx_reg];
    assign cur_ack   = ack_reg[idx_reg];
    assign cur_par   = slot_param_reg[idx_reg];
    assign last_slot = (idx_reg == SLOT_W'(NUM_SLOTS - 1));
    assign permitted = (32'(owner_reg) == 32'(tid_reg)) || (32'(owner_reg) == NUM_SLOTS);

    always_comb
    begin
        finish        = 1'b0;
        req_we        = 1'b0;
        ack_we        = 1'b0;
        par_we        = 1'b0;
        req_wdata     = SIG_NULL;
        ack_wdata     = SIG_NULL;
        res_delivered = 1'b0;
        res_accepted  = 1'b0;
        res_signal    = SIG_NULL;
        res_param     = '0;
        unique case (cmd_reg) inside
            CMD_UPDATE:
            begin
                if (!permitted)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    if (cur_ack != SIG_NULL && cur_req == SIG_NULL)
                    begin
                        ack_we = 1'b1;
                    end
                    else if (cur_req != SIG_NULL && cur_req != cur_ack)
                    begin
                        ack_we    = 1'b1;
                        ack_wdata = cur_req;
                        finish    = 1'b1;
                        res_signal = cur_req;
                    end
                    res_delivered = 1'b1;
                    res_param     = (res_signal != SIG_NULL) ? to_field(cur_par)
                                                             : to_field(to_slot(param_reg));
                    if (last_slot)
                    begin
                        finish = 1'b1;
                    end
                end
            end
            CMD_RESET:
            begin
                finish = 1'b1;
                if (range_ok_reg && cur_req != SIG_NULL && cur_req == cur_ack)
                begin
                    req_we = 1'b1;
                end
            end
            CMD_SEND, CMD_SEND_PARAM:
            begin
                finish = 1'b1;
                if (range_ok_reg && sig_reg != cur_ack)
                begin
                    req_we       = 1'b1;
                    req_wdata    = sig_reg;
                    par_we       = (cmd_reg == CMD_SEND_PARAM);
                    res_accepted = 1'b1;
                end
            end
            default:
            begin
                finish = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_WORK;
                    idx_next   = (cmd_t'(in_ch.command) == CMD_UPDATE) ? '0
                                                                        : SLOT_W'(in_ch.thread_id);
                end
            end
            ST_WORK:
            begin
                if (go)
                begin
                    if (finish)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + SLOT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            owner_reg     <= OWNER_W'(NUM_SLOTS);
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                req_reg[i]        <= SIG_NULL;
                ack_reg[i]        <= SIG_NULL;
                slot_param_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (cfg_we)
            begin
                owner_reg <= cfg_wdata;
            end
            if (go && req_we)
            begin
                req_reg[idx_reg] <= req_wdata;
            end
            if (go && ack_we)
            begin
                ack_reg[idx_reg] <= ack_wdata;
            end
            if (go && par_we)
            begin
                slot_param_reg[idx_reg] <= to_slot(param_reg);
            end
            if (go && finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg      <= cmd_t'(in_ch.command);
            tid_reg      <= in_ch.thread_id;
            sig_reg      <= in_ch.signal;
            param_reg    <= in_ch.param;
            range_ok_reg <= (32'(in_ch.thread_id) < NUM_SLOTS);
        end
        if (go && finish)
        begin
            delivered_reg      <= res_delivered;
            deliver_thread_reg <= res_delivered ? tid_reg : '0;
            deliver_signal_reg <= res_signal;
            deliver_param_reg  <= res_param;
            send_accepted_reg  <= res_accepted;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.delivered      = delivered_reg;
    assign out_ch.deliver_thread = deliver_thread_reg;
    assign out_ch.deliver_signal = deliver_signal_reg;
    assign out_ch.deliver_param  = deliver_param_reg;
    assign out_ch.send_accepted  = send_accepted_reg;

endmodule

// ===== design/ramb_chk.sv =====
module ramb_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          delivered,
    input logic [ramb_pkg::TID_W-1:0]    deliver_thread,
    input logic [ramb_pkg::SIG_W-1:0]    deliver_signal,
    input logic [ramb_pkg::FIELD_W-1:0]  deliver_param,
    input logic                          send_accepted
);
    import ramb_pkg::*;

    // A result item waiting to be taken is not withdrawn.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped before it was taken");

    // The block is busy in the cycle after it takes an item.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again without a working cycle");

    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(delivered && send_accepted))
        else $error("result reports both a delivery and an accepted send");

    // Without a delivery the delivery fields stay at zero.
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !delivered |->
            deliver_thread == '0 && deliver_signal == SIG_NULL && deliver_param == '0)
        else $error("delivery fields set on a result without a delivery");

endmodule

bind request_ack_mailbox_core ramb_chk u_ramb_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .delivered      (out_ch.delivered),
    .deliver_thread (out_ch.deliver_thread),
    .deliver_signal (out_ch.deliver_signal),
    .deliver_param  (out_ch.deliver_param),
    .send_accepted  (out_ch.send_accepted)
);

// ===== bench/request_ack_mailbox_core_tb.sv =====
`timescale 1ns / 1ps

module request_ack_mailbox_core_tb;
    import ramb_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 95;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_REPORTS   = 10;
    localparam logic [OWNER_W-1:0] OWNER_ANY  = OWNER_W'(NUM_SLOTS);
    localparam logic [OWNER_W-1:0] OWNER_NONE = '1;

    typedef struct packed {
        logic               delivered;
        logic [TID_W-1:0]   thr;
        logic [SIG_W-1:0]   sig;
        logic [FIELD_W-1:0] par;
        logic               accepted;
    } mbox_result_t;

    typedef struct {
        logic               is_cfg;
        logic [OWNER_W-1:0] owner;
        cmd_t               cmd;
        logic [TID_W-1:0]   tid;
        logic [SIG_W-1:0]   sig;
        logic [FIELD_W-1:0] par;
        logic               typed;
        mbox_result_t       res;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [OWNER_W-1:0] cfg_wdata;

    ramb_in_if  in_ch ();
    ramb_out_if out_ch ();

    request_ack_mailbox_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    logic [SIG_W-1:0]   req_sig  [NUM_SLOTS];
    logic [SIG_W-1:0]   ack_sig  [NUM_SLOTS];
    logic [FIELD_W-1:0] slot_par [NUM_SLOTS];
    logic [OWNER_W-1:0] owner_reg;

    mbox_result_t due_results[$];
    dir_row_t     dir_rows[$];

    int  mismatch_cnt;
    int  cycle_cnt;
    int  burst_left;
    int  stall_left;
    int  rx_mode;
    int  rx_mode_left;
    bit  hold_req;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic mbox_result_t mailbox_step(cmd_t c, logic [TID_W-1:0] t,
                                                  logic [SIG_W-1:0] s, logic [FIELD_W-1:0] p);
        mbox_result_t r;
        logic         found;
        r = '0;
        found = 1'b0;
        case (c)
            CMD_UPDATE:
            begin
                if (owner_reg == {1'b0, t} || owner_reg == OWNER_ANY)
                begin
                    r.delivered = 1'b1;
                    r.thr = t;
                    r.sig = SIG_NULL;
                    r.par = p;
                    for (int i = 0; i < NUM_SLOTS && !found; i++)
                    begin
                        if (ack_sig[i] != SIG_NULL && req_sig[i] == SIG_NULL)
                        begin
                            ack_sig[i] = SIG_NULL;
                        end
                        else if (req_sig[i] != SIG_NULL && req_sig[i] != ack_sig[i])
                        begin
                            ack_sig[i] = req_sig[i];
                            found = 1'b1;
                            r.sig = req_sig[i];
                            r.par = slot_par[i];
                        end
                    end
                end
            end
            CMD_RESET:
            begin
                if (req_sig[t] != SIG_NULL && req_sig[t] == ack_sig[t])
                begin
                    req_sig[t] = SIG_NULL;
                end
            end
            default:
            begin
                if (s != ack_sig[t])
                begin
                    req_sig[t] = s;
                    if (c == CMD_SEND_PARAM)
                    begin
                        slot_par[t] = p;
                    end
                    r.accepted = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    function automatic mbox_result_t mk_res(logic d, logic [TID_W-1:0] t, logic [SIG_W-1:0] s,
                                            logic [FIELD_W-1:0] p, logic a);
        mbox_result_t r;
        r.delivered = d;
        r.thr = t;
        r.sig = s;
        r.par = p;
        r.accepted = a;
        return r;
    endfunction

    function automatic dir_row_t item_row(cmd_t c, logic [TID_W-1:0] t, logic [SIG_W-1:0] s,
                                          logic [FIELD_W-1:0] p, logic typed,
                                          mbox_result_t r);
        dir_row_t row;
        row.is_cfg = 1'b0;
        row.owner = '0;
        row.cmd = c;
        row.tid = t;
        row.sig = s;
        row.par = p;
        row.typed = typed;
        row.res = r;
        return row;
    endfunction

    function automatic dir_row_t cfg_row(logic [OWNER_W-1:0] v);
        dir_row_t row;
        row = item_row(CMD_UPDATE, '0, '0, '0, 1'b0, '0);
        row.is_cfg = 1'b1;
        row.owner = v;
        return row;
    endfunction

    task automatic drain();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (due_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_owner(logic [OWNER_W-1:0] v);
        drain();
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we = 1'b0;
        owner_reg = v;
    endtask

    task automatic offer_item(cmd_t c, logic [TID_W-1:0] t, logic [SIG_W-1:0] s,
                              logic [FIELD_W-1:0] p, logic typed, mbox_result_t r);
        mbox_result_t pred;
        @(negedge clk);
        in_ch.valid = 1'b1;
        in_ch.command = c;
        in_ch.thread_id = t;
        in_ch.signal = s;
        in_ch.param = p;
        do
        begin
            @(posedge clk);
        end
        while (in_ch.ready !== 1'b1);
        pred = mailbox_step(c, t, s, p);
        due_results.push_back(typed ? r : pred);
    endtask

    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 10);
            @(negedge clk);
            in_ch.valid = 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    task automatic random_item();
        cmd_t               c;
        logic [TID_W-1:0]   t;
        logic [SIG_W-1:0]   s;
        logic [FIELD_W-1:0] p;
        int                 pick;
        pick = $urandom_range(0, 99);
        c = (pick < 35) ? CMD_UPDATE : (pick < 50) ? CMD_RESET :
            (pick < 75) ? CMD_SEND : CMD_SEND_PARAM;
        t = TID_W'($urandom_range(0, NUM_SLOTS - 1));
        if (c == CMD_UPDATE && owner_reg < OWNER_ANY && $urandom_range(0, 4) != 0)
        begin
            t = owner_reg[TID_W-1:0];
        end
        case ($urandom_range(0, 7))
            0:       s = SIG_NULL;
            1, 2:    s = ack_sig[t];
            3:       s = req_sig[t];
            4:       s = '1;
            default: s = SIG_W'($urandom_range(1, 255));
        endcase
        case ($urandom_range(0, 7))
            0:       p = '0;
            1:       p = '1;
            default: p = $urandom;
        endcase
        offer_item(c, t, s, p, 1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("request_ack_mailbox_core_tb: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        mbox_result_t got;
        mbox_result_t want;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            got = mk_res(out_ch.delivered, out_ch.deliver_thread, out_ch.deliver_signal,
                         out_ch.deliver_param, out_ch.send_accepted);
            if (due_results.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                begin
                    $display("unexpected result item: dlv=%0b thr=%0d sig=%02h par=%08h acc=%0b",
                             got.delivered, got.thr, got.sig, got.par, got.accepted);
                end
            end
            else
            begin
                want = due_results.pop_front();
                if (got !== want)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                    begin
                        $display("mismatch at %0t: expected dlv=%0b thr=%0d sig=%02h par=%08h acc=%0b",
                                 $realtime, want.delivered, want.thr, want.sig, want.par,
                                 want.accepted);
                        $display("                 actual   dlv=%0b thr=%0d sig=%02h par=%08h acc=%0b",
                                 got.delivered, got.thr, got.sig, got.par, got.accepted);
                    end
                end
            end
        end
    end

    initial
    begin
        out_ch.ready = 1'b0;
        stall_left = 0;
        rx_mode = 0;
        rx_mode_left = 0;
        hold_req = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (rx_mode_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(20, 120);
            end
            rx_mode_left--;
            if (stall_left > 0)
            begin
                out_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                out_ch.ready = 1'b1;
                case (rx_mode)
                    1:
                    begin
                        if ($urandom_range(0, 1) == 0)
                        begin
                            stall_left = $urandom_range(1, 3);
                        end
                    end
                    2:
                    begin
                        if ($urandom_range(0, 3) == 0)
                        begin
                            stall_left = $urandom_range(4, 15);
                        end
                    end
                    3:
                    begin
                        if ($urandom_range(0, 7) == 0)
                        begin
                            stall_left = 1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    initial
    begin
        logic [OWNER_W-1:0] phase_owner [PHASES];
        dir_row_t           row;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.command = '0;
        in_ch.thread_id = '0;
        in_ch.signal = '0;
        in_ch.param = '0;
        mismatch_cnt = 0;
        cycle_cnt = 0;
        burst_left = 0;
        owner_reg = OWNER_ANY;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            req_sig[i] = SIG_NULL;
            ack_sig[i] = SIG_NULL;
            slot_par[i] = '0;
        end

        dir_rows.push_back(item_row(CMD_UPDATE, 0, 8'h00, 32'h0000_0000, 1,
                                    mk_res(1, 0, 8'h00, 32'h0000_0000, 0)));
        dir_rows.push_back(item_row(CMD_UPDATE, 7, 8'h00, 32'hFFFF_FFFF, 1,
                                    mk_res(1, 7, 8'h00, 32'hFFFF_FFFF, 0)));
        dir_rows.push_back(item_row(CMD_SEND, 0, 8'h00, 32'h0, 1, mk_res(0, 0, 0, 0, 0)));
        dir_rows.push_back(item_row(CMD_SEND, 0, 8'hFF, 32'h0, 1, mk_res(0, 0, 0, 0, 1)));
        dir_rows.push_back(item_row(CMD_SEND_PARAM, 7, 8'h01, 32'hFFFF_FFFF, 1,
                                    mk_res(0, 0, 0, 0, 1)));
        dir_rows.push_back(item_row(CMD_RESET, 0, 8'h00, 32'h0, 1, mk_res(0, 0, 0, 0, 0)));
        dir_rows.push_back(item_row(CMD_UPDATE, 3, 8'h00, 32'h0000_1234, 1,
                                    mk_res(1, 3, 8'hFF, 32'h0000_0000, 0)));
        dir_rows.push_back(item_row(CMD_UPDATE, 3, 8'h00, 32'h0000_1234, 1,
                                    mk_res(1, 3, 8'h01, 32'hFFFF_FFFF, 0)));
        dir_rows.push_back(item_row(CMD_UPDATE, 5, 8'h00, 32'hAAAA_5555, 1,
                                    mk_res(1, 5, 8'h00, 32'hAAAA_5555, 0)));
        dir_rows.push_back(item_row(CMD_SEND, 0, 8'hFF, 32'h0, 1, mk_res(0, 0, 0, 0, 0)));
        dir_rows.push_back(item_row(CMD_SEND_PARAM, 0, 8'h80, 32'h5A5A_5A5A, 0, '0));
        dir_rows.push_back(item_row(CMD_UPDATE, 1, 8'hFF, 32'h1111_1111, 0, '0));
        dir_rows.push_back(item_row(CMD_RESET, 0, 8'h00, 32'h0, 0, '0));
        dir_rows.push_back(item_row(CMD_UPDATE, 2, 8'h00, 32'h2222_2222, 0, '0));
        dir_rows.push_back(item_row(CMD_SEND_PARAM, 4, 8'h00, 32'hDEAD_BEEF, 0, '0));
        dir_rows.push_back(cfg_row(3));
        dir_rows.push_back(item_row(CMD_UPDATE, 2, 8'h00, 32'h1234_5678, 1,
                                    mk_res(0, 0, 0, 0, 0)));
        dir_rows.push_back(item_row(CMD_SEND, 2, 8'h55, 32'h0, 0, '0));
        dir_rows.push_back(item_row(CMD_UPDATE, 3, 8'h00, 32'h8765_4321, 0, '0));
        dir_rows.push_back(cfg_row(OWNER_NONE));
        dir_rows.push_back(item_row(CMD_UPDATE, 7, 8'h00, 32'hFFFF_FFFF, 1,
                                    mk_res(0, 0, 0, 0, 0)));
        dir_rows.push_back(item_row(CMD_UPDATE, 0, 8'h00, 32'hFFFF_FFFF, 1,
                                    mk_res(0, 0, 0, 0, 0)));
        dir_rows.push_back(cfg_row(0));
        dir_rows.push_back(item_row(CMD_UPDATE, 0, 8'h00, 32'h0F0F_0F0F, 0, '0));
        dir_rows.push_back(cfg_row(OWNER_ANY));

        phase_owner[0] = OWNER_ANY;
        phase_owner[1] = OWNER_NONE;
        phase_owner[2] = 0;
        phase_owner[3] = 7;
        phase_owner[4] = OWNER_ANY;
        phase_owner[5] = OWNER_W'($urandom_range(0, 15));
        phase_owner[6] = OWNER_ANY;
        phase_owner[7] = OWNER_W'($urandom_range(0, 15));
        phase_owner[8] = OWNER_W'($urandom_range(0, 7));
        phase_owner[9] = OWNER_ANY;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.is_cfg)
            begin
                write_owner(row.owner);
            end
            else
            begin
                offer_item(row.cmd, row.tid, row.sig, row.par, row.typed, row.res);
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_owner(phase_owner[ph]);
            if (ph == 4)
            begin
                hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 6 && n == 40)
                begin
                    drain();
                end
                pace();
                random_item();
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatch_cnt == 0)
        begin
            $display("request_ack_mailbox_core_tb: clean");
        end
        else
        begin
            $display("request_ack_mailbox_core_tb: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/ramb_pkg.sv
design/ramb_in_if.sv
design/ramb_out_if.sv
design/request_ack_mailbox_core.sv
design/ramb_chk.sv
bench/request_ack_mailbox_core_tb.sv
